// File: hw/rtl/mac_learning_bridge_table_assert.svh
// ---------------------------------------------------------------------------
// mac learning bridge table assertion macros
// concurrent checks on clk with the asynchronous reset as disable
// ---------------------------------------------------------------------------
`ifndef MAC_LEARNING_BRIDGE_TABLE_ASSERT_SVH
`define MAC_LEARNING_BRIDGE_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MLBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MLBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MLBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MLBT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/mlbt_pkg.sv
// ---------------------------------------------------------------------------
// mlbt_pkg
// shared constants and types of the mac learning bridge table
// ---------------------------------------------------------------------------
package mlbt_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int MAC_W         = 48;
	localparam int PORT_W        = 6;
	localparam int TIME_W        = 32;
	localparam int ACT_W         = 2;
	localparam int IN_DATA_W     = 136;
	localparam int OUT_DATA_W    = 8;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(300);
	localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [ACT_W-1:0] {
		ACT_FORWARD    = 2'd0,
		ACT_DROP_SAME  = 2'd1,
		ACT_FLOOD      = 2'd2,
		ACT_DROP_SHORT = 2'd3
	} action_t;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] tstamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hw/rtl/mlbt_ram.sv
// ---------------------------------------------------------------------------
// mlbt_ram
// generic single-port synchronous ram with registered read
// ---------------------------------------------------------------------------
module mlbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: hw/rtl/mac_learning_bridge_table.sv
// ---------------------------------------------------------------------------
// mac_learning_bridge_table
// learning ethernet bridge table with aging, scanned from one ram
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  frame header item
// m_*       out  m_tvalid/m_tready  forwarding decision item
// cfg_*     in   cfg_we             aging timeout register
//
// a long frame scans the table one entry per cycle through the single ram
// port, then passes a drain step, a learn write, an age-out write when the
// stale destination entry is cleared, and the result; a short frame goes straight to the result
// after reset a clearing pass writes all TABLE_ENTRIES entries before s_tready
// the result sits in an output register, a stalled m_tready only holds the
// block once the next result is ready
// ---------------------------------------------------------------------------
`include "mac_learning_bridge_table_assert.svh"

module mac_learning_bridge_table
	import mlbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // src_mac, dst_mac, in_port, now_sec, zero pad
	input  logic                  s_tuser,  // short_frame
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // out_port, zero pad
	output logic [ACT_W-1:0]      m_tuser,  // action
	input  logic                  cfg_we,
	input  logic [TIME_W-1:0]     cfg_wdata
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_LEARN = 7'b0010000,
		ST_AGE   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [TIME_W-1:0] timeout_q;

	logic [MAC_W-1:0]  src_q;
	logic [MAC_W-1:0]  dst_q;
	logic [PORT_W-1:0] port_q;
	logic [TIME_W-1:0] now_q;

	logic              rd_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              src_hit_q;
	logic [IDX_W-1:0]  src_idx_q;
	logic              free_hit_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              dst_hit_q;
	logic [IDX_W-1:0]  dst_idx_q;
	logic [PORT_W-1:0] dst_port_q;
	logic [TIME_W-1:0] dst_time_q;

	action_t           res_act_q;
	logic [PORT_W-1:0] res_port_q;

	logic              out_valid_q;
	action_t           out_act_q;
	logic [PORT_W-1:0] out_port_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	entry_t            ram_wdata;
	entry_t            ram_rdata;

	logic              learned;
	logic              stale;
	logic              in_acc;
	logic              out_free;

	mlbt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign learned  = src_hit_q || free_hit_q;
	assign stale    = (dst_time_q > now_q) || ((now_q - dst_time_q) > timeout_q);

	always_comb begin
		ram_we           = 1'b0;
		ram_addr         = cnt_q;
		ram_wdata        = '0;
		ram_wdata.mac    = src_q;
		ram_wdata.port   = port_q;
		ram_wdata.tstamp = now_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_LEARN: begin
				ram_we          = learned;
				ram_addr        = src_hit_q ? src_idx_q : free_idx_q;
				ram_wdata.valid = 1'b1;
			end
			ST_AGE: begin
				ram_we    = 1'b1;
				ram_addr  = dst_idx_q;
				ram_wdata = '0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			src_q  <= s_tdata[MAC_W-1:0];
			dst_q  <= s_tdata[2*MAC_W-1:MAC_W];
			port_q <= s_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
			now_q  <= s_tdata[2*MAC_W+PORT_W+TIME_W-1:2*MAC_W+PORT_W];
		end
		idx_s1 <= cnt_q;
		if (in_acc) begin
			src_hit_q  <= 1'b0;
			free_hit_q <= 1'b0;
			dst_hit_q  <= 1'b0;
		end else if (rd_s1) begin
			if (ram_rdata.valid && ram_rdata.mac == src_q) begin
				src_hit_q <= 1'b1;
				src_idx_q <= idx_s1;
			end
			if (!ram_rdata.valid && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (ram_rdata.valid && ram_rdata.mac == dst_q) begin
				dst_hit_q  <= 1'b1;
				dst_idx_q  <= idx_s1;
				dst_port_q <= ram_rdata.port;
				dst_time_q <= ram_rdata.tstamp;
			end
		end
		if (in_acc) begin
			res_act_q  <= ACT_DROP_SHORT;
			res_port_q <= '0;
		end else if (state_q == ST_LEARN) begin
			res_port_q <= '0;
			if (dst_q == src_q) begin
				res_act_q <= learned ? ACT_DROP_SAME : ACT_FLOOD;
			end else if (!dst_hit_q || stale) begin
				res_act_q <= ACT_FLOOD;
			end else if (dst_port_q == port_q) begin
				res_act_q <= ACT_DROP_SAME;
			end else begin
				res_act_q  <= ACT_FORWARD;
				res_port_q <= dst_port_q;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			out_act_q  <= res_act_q;
			out_port_q <= res_port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						state_q <= s_tuser ? ST_OUT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_LEARN;
				end
				ST_LEARN: begin
					if (dst_q != src_q && dst_hit_q && stale) begin
						state_q <= ST_AGE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_AGE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_act_q;
	assign m_tdata  = {{(OUT_DATA_W-PORT_W){1'b0}}, out_port_q};

	`MLBT_ASSERT_IMP(a_rose_from_out, clk, arst_n, $rose(m_tvalid), $past(state_q == ST_OUT))
	`MLBT_ASSERT_IMP(a_age_clears, clk, arst_n, state_q == ST_AGE, ram_we && !ram_wdata.valid)
	`MLBT_ASSERT_IMP(a_port_zero, clk, arst_n, m_tvalid && m_tuser != ACT_FORWARD, m_tdata == '0)
	`MLBT_ASSERT_NXT(a_scan_drain, clk, arst_n, state_q == ST_DRAIN, state_q == ST_LEARN)

endmodule
